@@ rtl/piecewise_linear_color_ramp_macros.svh @@
// Assertion macros for the piecewise linear color ramp.
`ifndef PIECEWISE_LINEAR_COLOR_RAMP_MACROS_SVH
`define PIECEWISE_LINEAR_COLOR_RAMP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PLCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PLCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/plcr_pkg.sv @@
// Types and constants shared by the piecewise linear color ramp.
`default_nettype none

package plcr_pkg;

  localparam int LEVEL_W    = 17;
  localparam int POS_W      = 16;
  localparam int CHAN_W     = 8;
  localparam int CHAN_N     = 3;
  localparam int COLOR_W    = CHAN_N * CHAN_W;
  localparam int PROD_W     = CHAN_W + POS_W;
  localparam int COUNT_W    = 3;
  localparam int CFG_DATA_W = POS_W + COLOR_W;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_BREAK_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_FIRST = 3'd1;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [POS_W-1:0] pos_t;
  // Red in the low byte, then green, then blue.
  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    pos_t   pos;
    color_t color;
  } entry_t;

  localparam color_t COLOR_WHITE = '1;

endpackage

`default_nettype wire

@@ rtl/plcr_level_if.sv @@
// Handshake channel that carries one level word.
`default_nettype none

interface plcr_level_if import plcr_pkg::*; ();
  logic   valid;
  logic   ready;
  level_t level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

`default_nettype wire

@@ rtl/plcr_color_if.sv @@
// Handshake channel that carries one RGB color word.
`default_nettype none

interface plcr_color_if import plcr_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

@@ rtl/piecewise_linear_color_ramp.sv @@
// Top level of the piecewise linear color ramp: a level in, an RGB color out.
//
//   Channel   Direction  Word
//   levels    in         level, signed fraction
//   colors    out        red, green, blue
//   cfg_*     in         register writes, no handshake
//
// One word enters per cycle unless a stalled output backs up the stages; a result is
// offered after thirteen register stages: clamp, segment search, endpoint select,
// multiply, eight quotient-bit stages of the divider and a final add.
// Reset clears the break count, the break entries and all stage valid bits.
// A stalled output holds its word; each stage takes a new word whenever it is
// empty or its successor moves, so bubbles close up and nothing is lost.
`default_nettype none

`include "piecewise_linear_color_ramp_macros.svh"

module piecewise_linear_color_ramp import plcr_pkg::*; #(
  parameter int MAX_BREAKS    = 7,
  parameter int FRACTION_BITS = 15
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  plcr_level_if.sink                  levels,
  plcr_color_if.source                colors
);

  localparam int NSTAGE   = 4 + CHAN_W + 1;
  localparam int DIV_BASE = 3;
  localparam int DIV_LAST = DIV_BASE + CHAN_W;
  localparam logic [POS_W+8:0] ONE_FULL = (POS_W+9)'(1) << FRACTION_BITS;

  logic [COUNT_W-1:0] break_count;
  entry_t             entries [MAX_BREAKS];

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE:0]   rdy;
  logic [NSTAGE-1:0] vld_in;

  logic [LEVEL_W-1:0] s1_lvl;

  logic [MAX_BREAKS-1:0] s2_lo;
  logic [MAX_BREAKS-1:0] s2_hi;
  logic                  s2_white;
  logic                  s2_found;
  logic [LEVEL_W-1:0]    s2_lvl;

  color_t            s3_a;
  color_t            s3_mag;
  logic [CHAN_N-1:0] s3_neg;
  pos_t              s3_d;
  pos_t              s3_w;

  logic [PROD_W-1:0] dv_rem [CHAN_W+1][CHAN_N];
  color_t            dv_q   [CHAN_W+1];
  color_t            dv_a   [CHAN_W+1];
  logic [CHAN_N-1:0] dv_neg [CHAN_W+1];
  pos_t              dv_w   [CHAN_W+1];

  color_t out_col;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      break_count <= '0;
      for (int k = 0; k < MAX_BREAKS; k++) begin
        entries[k] <= '0;
      end
    end else if (cfg_write_en) begin
      if (cfg_index == REG_BREAK_COUNT) begin
        break_count <= cfg_data[COUNT_W-1:0];
      end
      for (int k = 0; k < MAX_BREAKS; k++) begin
        if (cfg_index == REG_ENTRY_FIRST + CFG_INDEX_W'(k)) begin
          entries[k] <= entry_t'(cfg_data);
        end
      end
    end
  end

  // Stage flow control.
  always_comb begin
    rdy[NSTAGE] = colors.ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vld_in = {vld[NSTAGE-2:0], levels.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign levels.ready = rdy[0];

  // Stage 1: clamp the level to 0..1.0.
  logic [POS_W-1:0]   lvl_pos;
  logic [LEVEL_W-1:0] lvl_clamped;

  always_comb begin
    lvl_pos = levels.level[LEVEL_W-1] ? '0 : levels.level[POS_W-1:0];
    if ({9'b0, lvl_pos} > ONE_FULL) begin
      lvl_clamped = ONE_FULL[LEVEL_W-1:0];
    end else begin
      lvl_clamped = {1'b0, lvl_pos};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_lvl <= lvl_clamped;
    end
  end

  // Stage 2: find the first enclosing segment, or else select the last active break.
  logic [COUNT_W-1:0]    n_eff;
  logic [MAX_BREAKS-1:0] sel_lo;
  logic [MAX_BREAKS-1:0] sel_hi;
  logic                  found;

  always_comb begin
    n_eff  = (break_count > COUNT_W'(MAX_BREAKS)) ? COUNT_W'(MAX_BREAKS) : break_count;
    sel_lo = '0;
    sel_hi = '0;
    found  = 1'b0;
    if (n_eff >= COUNT_W'(2)) begin
      for (int i = 1; i < MAX_BREAKS; i++) begin
        if (!found && COUNT_W'(i) < n_eff &&
            s1_lvl >= {1'b0, entries[i-1].pos} && s1_lvl <= {1'b0, entries[i].pos}) begin
          found         = 1'b1;
          sel_lo[i-1]   = 1'b1;
          sel_hi[i]     = 1'b1;
        end
      end
    end
    if (!found) begin
      for (int k = 0; k < MAX_BREAKS; k++) begin
        sel_lo[k] = (n_eff == COUNT_W'(k + 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_lo    <= sel_lo;
      s2_hi    <= sel_hi;
      s2_found <= found;
      s2_white <= (n_eff == '0);
      s2_lvl   <= s1_lvl;
    end
  end

  // Stage 3: pick the segment ends and form the spans.
  color_t            a_col;
  color_t            b_col;
  pos_t              p0;
  pos_t              p1;
  logic              interp;
  chan_t             av;
  chan_t             bv;
  color_t            mag;
  logic [CHAN_N-1:0] neg;

  always_comb begin
    a_col = '0;
    b_col = '0;
    p0    = '0;
    p1    = '0;
    for (int k = 0; k < MAX_BREAKS; k++) begin
      a_col = a_col | (entries[k].color & {COLOR_W{s2_lo[k]}});
      b_col = b_col | (entries[k].color & {COLOR_W{s2_hi[k]}});
      p0    = p0 | (entries[k].pos & {POS_W{s2_lo[k]}});
      p1    = p1 | (entries[k].pos & {POS_W{s2_hi[k]}});
    end
    if (s2_white) begin
      a_col = COLOR_WHITE;
    end
    interp = s2_found && (p1 != p0);
    mag    = '0;
    neg    = '0;
    for (int ch = 0; ch < CHAN_N; ch++) begin
      av = a_col[ch*CHAN_W +: CHAN_W];
      bv = b_col[ch*CHAN_W +: CHAN_W];
      if (interp) begin
        if (bv >= av) begin
          mag[ch*CHAN_W +: CHAN_W] = bv - av;
        end else begin
          mag[ch*CHAN_W +: CHAN_W] = av - bv;
          neg[ch]                  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_a   <= a_col;
      s3_mag <= mag;
      s3_neg <= neg;
      s3_d   <= interp ? (s2_lvl[POS_W-1:0] - p0) : '0;
      s3_w   <= interp ? (p1 - p0) : POS_W'(1);
    end
  end

  // Stage 4: span times offset, one product per channel.
  always_ff @(posedge clk) begin
    if (rdy[DIV_BASE]) begin
      for (int ch = 0; ch < CHAN_N; ch++) begin
        dv_rem[0][ch] <= PROD_W'(s3_mag[ch*CHAN_W +: CHAN_W]) * PROD_W'(s3_d);
      end
      dv_q[0]   <= '0;
      dv_a[0]   <= s3_a;
      dv_neg[0] <= s3_neg;
      dv_w[0]   <= s3_w;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar s = 1; s <= CHAN_W; s++) begin : g_div
    localparam int SH = CHAN_W - s;
    logic [PROD_W-1:0] trial;

    assign trial = PROD_W'(dv_w[s-1]) << SH;

    always_ff @(posedge clk) begin
      if (rdy[DIV_BASE + s]) begin
        for (int ch = 0; ch < CHAN_N; ch++) begin
          if (dv_rem[s-1][ch] >= trial) begin
            dv_rem[s][ch]                  <= dv_rem[s-1][ch] - trial;
            dv_q[s][ch*CHAN_W +: CHAN_W]   <= {dv_q[s-1][ch*CHAN_W +: CHAN_W-1], 1'b1};
          end else begin
            dv_rem[s][ch]                  <= dv_rem[s-1][ch];
            dv_q[s][ch*CHAN_W +: CHAN_W]   <= {dv_q[s-1][ch*CHAN_W +: CHAN_W-1], 1'b0};
          end
        end
        dv_a[s]   <= dv_a[s-1];
        dv_neg[s] <= dv_neg[s-1];
        dv_w[s]   <= dv_w[s-1];
      end
    end
  end

  // Final stage: lower color plus or minus the quotient.
  always_ff @(posedge clk) begin
    if (rdy[NSTAGE-1]) begin
      for (int ch = 0; ch < CHAN_N; ch++) begin
        if (dv_neg[CHAN_W][ch]) begin
          out_col[ch*CHAN_W +: CHAN_W] <=
            dv_a[CHAN_W][ch*CHAN_W +: CHAN_W] - dv_q[CHAN_W][ch*CHAN_W +: CHAN_W];
        end else begin
          out_col[ch*CHAN_W +: CHAN_W] <=
            dv_a[CHAN_W][ch*CHAN_W +: CHAN_W] + dv_q[CHAN_W][ch*CHAN_W +: CHAN_W];
        end
      end
    end
  end

  assign colors.valid = vld[NSTAGE-1];
  assign colors.red   = out_col[0*CHAN_W +: CHAN_W];
  assign colors.green = out_col[1*CHAN_W +: CHAN_W];
  assign colors.blue  = out_col[2*CHAN_W +: CHAN_W];

  `PLCR_ASSERT_NEXT(take_fills_first_a, levels.valid && levels.ready, vld[0], "accepted level did not enter the first stage")
  `PLCR_ASSERT_NOW(empty_out_ready_a, !vld[NSTAGE-1], levels.ready, "input stalled while the output stage is empty")
  `PLCR_ASSERT_NOW(red_rem_a, vld[DIV_LAST], dv_rem[CHAN_W][0] < PROD_W'(dv_w[CHAN_W]), "red remainder not below divisor")
  `PLCR_ASSERT_NOW(green_rem_a, vld[DIV_LAST], dv_rem[CHAN_W][1] < PROD_W'(dv_w[CHAN_W]), "green remainder not below divisor")
  `PLCR_ASSERT_NOW(blue_rem_a, vld[DIV_LAST], dv_rem[CHAN_W][2] < PROD_W'(dv_w[CHAN_W]), "blue remainder not below divisor")

endmodule

`default_nettype wire

@@ tb/sv/piecewise_linear_color_ramp_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the piecewise linear color ramp: directed ramps, random ramps, stalls.
module piecewise_linear_color_ramp_test;
  import plcr_pkg::*;

  localparam int RAMP_MAX_BREAKS = 7;
  localparam int RAMP_FRACTION_BITS = 15;
  localparam int ONE_LEVEL = 1 << RAMP_FRACTION_BITS;
  localparam int ENTRY_SLOTS = 7;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } rgb_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  plcr_level_if level_ch ();
  plcr_color_if color_ch ();

  piecewise_linear_color_ramp #(
    .MAX_BREAKS(RAMP_MAX_BREAKS),
    .FRACTION_BITS(RAMP_FRACTION_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .levels(level_ch),
    .colors(color_ch)
  );

  logic [COUNT_W-1:0] ramp_count;
  entry_t ramp_entry [ENTRY_SLOTS];
  entry_t staged_entry [ENTRY_SLOTS];
  rgb_t color_expect [$];
  int mismatch_count = 0;
  int level_gap_max = 0;
  int color_gap_max = 0;
  int color_hold = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAIL piecewise_linear_color_ramp");
    $finish;
  end

  function automatic rgb_t predict_color(input level_t lv);
    int n, clamped, seg, k, ch, p_lo, p_hi, w, d, a, b, v;
    entry_t lo, hi;
    rgb_t res;
    n = int'(ramp_count);
    if (n > RAMP_MAX_BREAKS) n = RAMP_MAX_BREAKS;
    if (n == 0) return rgb_t'(COLOR_WHITE);
    if (n == 1) return rgb_t'(ramp_entry[0].color);
    clamped = int'(lv);
    if (clamped < 0) clamped = 0;
    if (clamped > ONE_LEVEL) clamped = ONE_LEVEL;
    seg = 0;
    for (k = 1; k < n; k++) begin
      p_lo = int'(ramp_entry[k-1].pos);
      p_hi = int'(ramp_entry[k].pos);
      if (seg == 0 && clamped >= p_lo && clamped <= p_hi) seg = k;
    end
    if (seg == 0) return rgb_t'(ramp_entry[n-1].color);
    lo = ramp_entry[seg-1];
    hi = ramp_entry[seg];
    p_lo = int'(lo.pos);
    w = int'(hi.pos) - p_lo;
    d = clamped - p_lo;
    if (w <= 0) return rgb_t'(lo.color);
    res = '0;
    for (ch = 0; ch < CHAN_N; ch++) begin
      a = int'(lo.color[CHAN_W*ch +: CHAN_W]);
      b = int'(hi.color[CHAN_W*ch +: CHAN_W]);
      v = a + ((b - a) * d) / w;
      res[CHAN_W*ch +: CHAN_W] = chan_t'(v);
    end
    return res;
  endfunction

  function automatic level_t random_level();
    case ($urandom_range(0, 9))
      0: return level_t'($urandom());
      1: return level_t'(ramp_entry[$urandom_range(0, ENTRY_SLOTS - 1)].pos);
      2: return ($urandom_range(0, 1) != 0) ? level_t'(ONE_LEVEL) : level_t'(0);
      default: return level_t'($urandom_range(0, ONE_LEVEL));
    endcase
  endfunction

  task automatic send_level(input level_t lv);
    int gap;
    gap = $urandom_range(0, level_gap_max);
    if (gap > 0) begin
      level_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    level_ch.valid <= 1'b1;
    level_ch.level <= lv;
    do @(negedge clk); while (!level_ch.ready);
    @(posedge clk);
    color_expect.insert(color_expect.size(), predict_color(lv));
  endtask

  task automatic wait_drained();
    level_ch.valid <= 1'b0;
    while (color_expect.size() != 0) @(posedge clk);
  endtask

  task automatic write_ramp(input logic [COUNT_W-1:0] count);
    int k;
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_index <= REG_BREAK_COUNT;
    cfg_data <= CFG_DATA_W'(count);
    @(posedge clk);
    ramp_count = count;
    for (k = 0; k < ENTRY_SLOTS; k++) begin
      cfg_index <= REG_ENTRY_FIRST + CFG_INDEX_W'(k);
      cfg_data <= staged_entry[k];
      @(posedge clk);
      ramp_entry[k] = staged_entry[k];
    end
    cfg_write_en <= 1'b0;
  endtask

  task automatic test_reset_white();
    send_level(level_t'(0));
    send_level(level_t'(ONE_LEVEL));
    send_level(level_t'(-65536));
    send_level(level_t'(65535));
  endtask

  task automatic test_single_break();
    int k;
    for (k = 0; k < ENTRY_SLOTS; k++) staged_entry[k] = {16'hFFFF, 24'hFFFFFF};
    staged_entry[0] = {16'd20000, 24'h8040C0};
    write_ramp(3'd1);
    send_level(level_t'(0));
    send_level(level_t'(20000));
    send_level(level_t'(-1));
  endtask

  task automatic test_ramp_segments();
    // Zero-width first segment, a falling segment, unordered and out-of-range positions.
    staged_entry[0] = {16'd0, 24'h000000};
    staged_entry[1] = {16'd0, 24'hFFFFFF};
    staged_entry[2] = {16'd8192, 24'h123456};
    staged_entry[3] = {16'd4096, 24'hABCDEF};
    staged_entry[4] = {16'd32768, 24'h00FF80};
    staged_entry[5] = {16'd65535, 24'hFFFFFF};
    staged_entry[6] = {16'd65535, 24'h0000FF};
    write_ramp(3'd7);
    send_level(level_t'(0));
    send_level(level_t'(6000));
    send_level(level_t'(8192));
    send_level(level_t'(20000));
    send_level(level_t'(32767));
    send_level(level_t'(32768));
    send_level(level_t'(32769));
    send_level(level_t'(-5));
  endtask

  task automatic test_no_enclosing_segment();
    staged_entry[0] = {16'd10000, 24'h0A0B0C};
    staged_entry[1] = {16'd20000, 24'hF0E0D0};
    write_ramp(3'd2);
    send_level(level_t'(0));
    send_level(level_t'(ONE_LEVEL));
    send_level(level_t'(15000));
  endtask

  task automatic test_random_ramps(input int item_total);
    int sent, burst, n, k, p, step, i;
    bit scrambled;
    sent = 0;
    while (sent < item_total) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, RAMP_MAX_BREAKS);
      scrambled = ($urandom_range(0, 5) == 0);
      p = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8192) : 0;
      step = ONE_LEVEL / ((n > 1) ? n - 1 : 1);
      for (k = 0; k < ENTRY_SLOTS; k++) begin
        staged_entry[k].color = color_t'($urandom());
        if (scrambled) begin
          staged_entry[k].pos = pos_t'($urandom());
        end else begin
          staged_entry[k].pos = pos_t'(p);
          p = p + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2 * step));
          if (p > 65535) p = 65535;
        end
      end
      if (!scrambled && n >= 2 && $urandom_range(0, 1) != 0) begin
        staged_entry[n-1].pos = pos_t'(ONE_LEVEL);
      end
      write_ramp(COUNT_W'(n));
      level_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      color_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
      burst = $urandom_range(40, 120);
      for (i = 0; i < burst; i++) send_level(random_level());
      sent += burst;
    end
  endtask

  task automatic test_backpressure();
    int i;
    level_gap_max = 0;
    color_hold = 400;
    for (i = 0; i < 80; i++) send_level(random_level());
  endtask

  initial begin
    rgb_t got;
    rgb_t want;
    int stall;
    color_ch.ready <= 1'b0;
    do @(negedge clk); while (rst !== 1'b0);
    @(posedge clk);
    forever begin
      if (color_hold > 0) begin
        color_ch.ready <= 1'b0;
        repeat (color_hold) @(posedge clk);
        color_hold = 0;
      end
      stall = $urandom_range(0, color_gap_max);
      if (stall > 0) begin
        color_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      color_ch.ready <= 1'b1;
      do @(negedge clk); while (!color_ch.valid);
      got = '{blue: color_ch.blue, green: color_ch.green, red: color_ch.red};
      @(posedge clk);
      if (color_expect.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        mismatch_count++;
      end else begin
        want = color_expect.pop_front();
        if (got.red !== want.red) begin
          $display("%0t: red: expected %0d, actual %0d", $time, want.red, got.red);
          mismatch_count++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green: expected %0d, actual %0d", $time, want.green, got.green);
          mismatch_count++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue: expected %0d, actual %0d", $time, want.blue, got.blue);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int k;
    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    level_ch.valid <= 1'b0;
    level_ch.level <= '0;
    ramp_count = '0;
    for (k = 0; k < ENTRY_SLOTS; k++) ramp_entry[k] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_white();
    test_single_break();
    test_ramp_segments();
    test_no_enclosing_segment();
    test_random_ramps(1820);
    test_backpressure();
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS piecewise_linear_color_ramp");
    end else begin
      $display("FAIL piecewise_linear_color_ramp");
    end
    $finish;
  end

endmodule

@@ piecewise_linear_color_ramp.f @@
+incdir+rtl
rtl/plcr_pkg.sv
rtl/plcr_level_if.sv
rtl/plcr_color_if.sv
rtl/piecewise_linear_color_ramp.sv
tb/sv/piecewise_linear_color_ramp_test.sv
